FILE: design/stb_pkg.sv
// ----------------------------------------------------------------------------
// stb_pkg
// Shared constants for the sorted-table lookup engine: table geometry,
// request codes and the result field widths.
// ----------------------------------------------------------------------------
package stb_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int KEY_WIDTH   = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Entry count field and its saturation limit
    localparam int         COUNT_W   = 8;
    localparam int         COUNT_IN_W = 16;
    localparam logic [7:0] COUNT_MAX = 8'd255;

    // Entry word in the table memory: count above key
    localparam int ENTRY_W = KEY_WIDTH + COUNT_W;

    // Result index field width
    localparam int OUT_IDX_W = 12;

    // Request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

endpackage

FILE: design/stb_ram.sv
// ----------------------------------------------------------------------------
// stb_ram
// Generic single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module stb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: design/sorted_table_binary_search.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Sorted-table lookup engine: appends entries, clears the table and runs a
// binary search for query keys over a single-port table memory.
// ----------------------------------------------------------------------------
// One input beat is worked at a time and gives one result beat. For an append,
// a clear or an unused code the sequencer goes from acceptance straight to the
// finish state, which loads the result register once the output register is
// free, and the next beat is accepted after that. A query first runs P probes,
// at most floor(log2(entries)) + 1, i.e. up to 13 for a full 4096-entry table,
// and then passes through the finish state. Each probe is the table memory's
// registered read, compared against the key, with the next midpoint address
// issued in the same cycle. The result sits in its own output register, so the
// next beat is accepted while a result still waits to be taken. Appends must
// arrive in ascending key order; the table is never sorted. The table memory
// is not cleared after reset: only entries below the fill count are read.
module sorted_table_binary_search (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: bit 0 = invert_presence
    input  logic        cfg_wen,
    input  logic        cfg_wdata,
    // request channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [63:0] key, [79:64] count_in
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [0] status, [1] hit, [2] present,
                                   // [14:3] found_index, [22:15] found_count,
                                   // [23] zero
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_FIN   = 2'd2;

    localparam int CW = stb_pkg::CNT_W;
    localparam int IW = stb_pkg::IDX_W;
    localparam int KW = stb_pkg::KEY_WIDTH;

    // midpoint of the half-open window [lo, hi)
    function automatic logic [IW-1:0] mid_of(input logic [CW-1:0] lo,
                                             input logic [CW-1:0] hi);
        logic [CW:0] sum;
        sum = {1'b0, lo} + {1'b0, hi} - (CW+1)'(1);
        return sum[IW:1];
    endfunction

    // state
    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] entry_total_reg, entry_total_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [IW-1:0] mid_reg, mid_next;
    logic          invert_reg;
    logic          res_status_reg, res_status_next;
    logic          res_hit_reg, res_hit_next;
    logic          m_valid_reg, m_valid_next;
    // payload
    logic [1:0]    req_reg, req_next;
    logic [KW-1:0] key_reg, key_next;
    logic [7:0]    res_count_reg, res_count_next;
    logic [23:0]   m_data_reg, m_data_next;

    // table memory
    logic                        ram_we;
    logic [IW-1:0]               ram_addr;
    logic [stb_pkg::ENTRY_W-1:0] ram_wdata;
    logic [stb_pkg::ENTRY_W-1:0] ram_rdata;

    stb_ram #(
        .WIDTH (stb_pkg::ENTRY_W),
        .DEPTH (stb_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // request fields
    logic                          accept;
    logic [1:0]                    in_req;
    logic [KW-1:0]                 in_key;
    logic [stb_pkg::COUNT_IN_W-1:0] in_count;
    logic [7:0]                    sat_count;
    logic                          table_full;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid & s_tready;
    assign in_req     = s_tuser;
    assign in_key     = s_tdata[KW-1:0];
    assign in_count   = s_tdata[79:64];
    assign sat_count  = (in_count > stb_pkg::COUNT_IN_W'(stb_pkg::COUNT_MAX))
                        ? stb_pkg::COUNT_MAX : in_count[7:0];
    assign table_full = (entry_total_reg == CW'(stb_pkg::TABLE_DEPTH));

    // probe compare
    logic [KW-1:0] probe_key;
    logic [7:0]    probe_count;
    logic          probe_eq, probe_lt;
    logic [CW-1:0] lo_step, hi_step;

    assign probe_key   = ram_rdata[KW-1:0];
    assign probe_count = ram_rdata[KW +: stb_pkg::COUNT_W];
    assign probe_eq    = (probe_key == key_reg);
    assign probe_lt    = (probe_key < key_reg);
    assign lo_step     = probe_lt ? (CW'(mid_reg) + CW'(1)) : lo_reg;
    assign hi_step     = probe_lt ? hi_reg : CW'(mid_reg);

    // result word
    logic          res_present;

    assign res_present = (req_reg == stb_pkg::REQ_QUERY) & (res_hit_reg ^ invert_reg);

    // sequencer
    always_comb begin
        state_next       = state_reg;
        entry_total_next = entry_total_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        res_status_next  = res_status_reg;
        res_hit_next     = res_hit_reg;
        res_count_next   = res_count_reg;
        req_next         = req_reg;
        key_next         = key_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        ram_we           = 1'b0;
        ram_addr         = mid_reg;
        ram_wdata        = {sat_count, in_key};

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next        = in_req;
                    key_next        = in_key;
                    res_status_next = 1'b0;
                    res_hit_next    = 1'b0;
                    state_next      = ST_FIN;
                    case (in_req)
                        stb_pkg::REQ_APPEND: begin
                            if (table_full) begin
                                res_status_next = 1'b1;
                            end else begin
                                ram_we           = 1'b1;
                                ram_addr         = entry_total_reg[IW-1:0];
                                entry_total_next = entry_total_reg + CW'(1);
                            end
                        end
                        stb_pkg::REQ_QUERY: begin
                            lo_next = '0;
                            hi_next = entry_total_reg;
                            if (entry_total_reg != '0) begin
                                mid_next   = mid_of('0, entry_total_reg);
                                ram_addr   = mid_next;
                                state_next = ST_PROBE;
                            end
                        end
                        stb_pkg::REQ_CLEAR: begin
                            entry_total_next = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (probe_eq) begin
                    res_hit_next   = 1'b1;
                    res_count_next = probe_count;
                    state_next     = ST_FIN;
                end else begin
                    lo_next = lo_step;
                    hi_next = hi_step;
                    if (lo_step < hi_step) begin
                        mid_next = mid_of(lo_step, hi_step);
                        ram_addr = mid_next;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0,
                                    res_hit_reg ? res_count_reg : 8'd0,
                                    res_hit_reg ? stb_pkg::OUT_IDX_W'(mid_reg)
                                                : stb_pkg::OUT_IDX_W'(0),
                                    res_present, res_hit_reg, res_status_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            entry_total_reg <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            mid_reg         <= '0;
            invert_reg      <= 1'b0;
            res_status_reg  <= 1'b0;
            res_hit_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            entry_total_reg <= entry_total_next;
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            mid_reg         <= mid_next;
            res_status_reg  <= res_status_next;
            res_hit_reg     <= res_hit_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wen) begin
                invert_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        key_reg       <= key_next;
        res_count_reg <= res_count_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // fill count never passes the table depth
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_total_reg <= CW'(stb_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // every probe lies inside a non-empty window of filled entries
    a_probe_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PROBE) |-> (lo_reg < hi_reg) && (CW'(mid_reg) >= lo_reg)
            && (CW'(mid_reg) < hi_reg) && (hi_reg <= entry_total_reg))
        else $error("probe outside search window");

    // a miss reports zero index and count
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg[1]) |-> (m_data_reg[22:3] == '0))
        else $error("miss with nonzero index or count");

    // an append into a table with room is stored and reports no drop status
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_req == stb_pkg::REQ_APPEND && !table_full)
            |=> (entry_total_reg == $past(entry_total_reg) + CW'(1)) && !res_status_reg)
        else $error("append not stored while table had room");

endmodule
